// ----- rtl/bsm_pkg.sv -----
// Package for the byte substring matcher: default sizes, configuration
// register indexes, the result record and the byte compare helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bsm_pkg;

    localparam int NEEDLE_MAX_DEF  = 16;
    localparam int OFFSET_BITS_DEF = 32;

    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 64;
    localparam int NEEDLE_LEN_W   = 5;
    localparam int START_OFFSET_W = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NEEDLE_LOW  = 2'd0,
        CFG_NEEDLE_HIGH = 2'd1,
        CFG_NEEDLE_LEN  = 2'd2,
        CFG_CASELESS    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic                      found;
        logic [START_OFFSET_W-1:0] start_offset;
    } result_t;

    function automatic logic [7:0] ascii_lower(input logic [7:0] c);
        ascii_lower = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    // Haystack byte h against needle byte n.
    function automatic logic byte_ok(input logic [7:0] h, input logic [7:0] n,
                                     input logic caseless);
        byte_ok = (h == n) || (caseless && (h == ascii_lower(n)));
    endfunction

endpackage

`default_nettype wire

// ----- rtl/byte_substring_matcher.sv -----
// Byte substring matcher top level: needle registers, window of recent bytes,
// one-pass compare and a two-entry result buffer. Depends on bsm_pkg.
//
// Latency: a result is on m_tvalid in the cycle after the transfer of the byte
// that causes it (the matching byte, or the final byte of a haystack) when the
// output register is free; behind a waiting result it follows that transfer.
// Throughput: one byte per cycle; s_tready drops only while two results wait.
// Reset: asynchronous, active low; clears needle config, window, byte count
// and the result buffer.
`timescale 1ns / 1ps
`default_nettype none

module byte_substring_matcher
    import bsm_pkg::*;
#(
    parameter int NEEDLE_MAX  = NEEDLE_MAX_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // configuration write port
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     cfg_data,
    // haystack stream
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [7:0]                s_tdata,    // data_byte
    input  wire logic                      s_tlast,    // final_byte
    // result stream
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [START_OFFSET_W-1:0]      m_tdata,    // start_offset
    output logic                           m_tuser     // found
);

    localparam int LEN_W    = $clog2(NEEDLE_MAX + 1);
    localparam int IDX_W    = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
    localparam int RECENT_D = (NEEDLE_MAX > 1) ? NEEDLE_MAX - 1 : 1;

    // configuration
    logic [2*CFG_DATA_W-1:0]   needle_reg;
    logic [NEEDLE_LEN_W-1:0]   needle_len_reg;
    logic                      caseless_reg;

    // haystack state
    logic [7:0]                recent_reg [RECENT_D];
    logic [OFFSET_BITS-1:0]    bytes_seen_reg;
    logic                      reported_reg;

    // result buffer
    result_t                   out_reg, skid_reg;
    logic                      out_valid_reg, skid_valid_reg;

    logic                      accept, pop, push, hit;
    logic [LEN_W-1:0]          len_eff;
    logic [7:0]                win [NEEDLE_MAX];
    logic [OFFSET_BITS-1:0]    diff;
    result_t                   new_res;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.start_offset;
    assign m_tuser  = out_reg.found;

    assign len_eff = (needle_len_reg > NEEDLE_LEN_W'(NEEDLE_MAX))
                   ? LEN_W'(NEEDLE_MAX) : LEN_W'(needle_len_reg);

    always_comb
    begin
        win[0] = s_tdata;
        for (int k = 1; k < NEEDLE_MAX; k++)
        begin
            win[k] = recent_reg[k-1];
        end
    end

    // Needle byte i lines up with the byte len-1-i positions back.
    always_comb
    begin
        logic [LEN_W-1:0] sel;
        hit = (len_eff != '0) && !reported_reg
           && (bytes_seen_reg >= OFFSET_BITS'(len_eff - LEN_W'(1)));
        for (int i = 0; i < NEEDLE_MAX; i++)
        begin
            sel = LEN_W'(int'(len_eff) - 1 - i);
            if (i < int'(len_eff)
                && !byte_ok(win[sel[IDX_W-1:0]], needle_reg[8*i +: 8], caseless_reg))
            begin
                hit = 1'b0;
            end
        end
    end

    assign diff = bytes_seen_reg - OFFSET_BITS'(len_eff - LEN_W'(1));

    always_comb
    begin
        new_res.found        = hit;
        new_res.start_offset = hit ? START_OFFSET_W'(diff) : '0;
    end

    assign push = accept && (hit || (s_tlast && !reported_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_reg     <= '0;
            needle_len_reg <= '0;
            caseless_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_NEEDLE_LOW:  needle_reg[CFG_DATA_W-1:0] <= cfg_data;
                CFG_NEEDLE_HIGH: needle_reg[2*CFG_DATA_W-1:CFG_DATA_W] <= cfg_data;
                CFG_NEEDLE_LEN:  needle_len_reg <= cfg_data[NEEDLE_LEN_W-1:0];
                CFG_CASELESS:    caseless_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < RECENT_D; k++)
            begin
                recent_reg[k] <= '0;
            end
            bytes_seen_reg <= '0;
            reported_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                // end of haystack: start the next one clean
                for (int k = 0; k < RECENT_D; k++)
                begin
                    recent_reg[k] <= '0;
                end
                bytes_seen_reg <= '0;
                reported_reg   <= 1'b0;
            end
            else
            begin
                recent_reg[0] <= s_tdata;
                for (int k = 1; k < RECENT_D; k++)
                begin
                    recent_reg[k] <= recent_reg[k-1];
                end
                if (bytes_seen_reg != '1)
                begin
                    bytes_seen_reg <= bytes_seen_reg + OFFSET_BITS'(1);
                end
                if (hit)
                begin
                    reported_reg <= 1'b1;
                end
            end
        end
    end

    // Two-entry result buffer: out_reg drives the port, skid_reg holds one more.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || pop)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= push;
                end
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            out_reg <= skid_valid_reg ? skid_reg : new_res;
        end
        else if (push)
        begin
            skid_reg <= new_res;
        end
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (!reported_reg && bytes_seen_reg == '0))
        else $error("haystack state not cleared after final byte");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("not-found result carries a nonzero offset");

    a_one_per_haystack: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && reported_reg) |-> !push)
        else $error("second result for one haystack");

endmodule

`default_nettype wire

// ----- tb/byte_substring_matcher_tb.sv -----
// Testbench for byte_substring_matcher: directed and random haystacks checked
// against a built-in predictor of the first-match search.
// Depends on bsm_pkg and the byte_substring_matcher RTL.
`timescale 1ns / 1ps

module byte_substring_matcher_tb;
    import bsm_pkg::*;

    localparam int WIN_DEPTH   = NEEDLE_MAX_DEF - 1;
    localparam int SETTLE_CYC  = 4;
    localparam int RANDOM_BYTES = 1750;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data = '0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [7:0]                   s_tdata = '0;    // data_byte
    logic                         s_tlast = 1'b0;  // final_byte
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [START_OFFSET_W-1:0]    m_tdata;         // start_offset
    logic                         m_tuser;         // found

    // needle configuration as the block should hold it
    logic [7:0]  ndl [NEEDLE_MAX_DEF];
    logic [4:0]  ndl_len = '0;
    logic        ndl_caseless = 1'b0;

    // haystack state
    logic [7:0]  win_bytes [WIN_DEPTH];
    logic [31:0] hay_count = '0;
    logic        hay_reported = 1'b0;

    result_t     pending_matches [$];
    int          errors = 0;
    int          rx_hold = 0;
    bit          steady = 1'b0;

    byte_substring_matcher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic [127:0] pack_text(input string s);
        logic [127:0] r;
        r = '0;
        for (int i = 0; i < s.len() && i < 16; i++)
            r[8*i +: 8] = s[i];
        return r;
    endfunction

    function automatic int needle_span();
        return (ndl_len > NEEDLE_MAX_DEF) ? NEEDLE_MAX_DEF : int'(ndl_len);
    endfunction

    task automatic log_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endtask

    task automatic clear_haystack();
        for (int i = 0; i < WIN_DEPTH; i++)
            win_bytes[i] = '0;
        hay_count = '0;
        hay_reported = 1'b0;
    endtask

    // Advance the search by one accepted byte and queue any result it causes.
    task automatic scan_byte(input logic [7:0] d, input logic last);
        int      span;
        bit      hit;
        int      lag;
        logic [7:0] h;
        result_t r;
        span = needle_span();
        if (!hay_reported && span != 0 && ({1'b0, hay_count} + 33'd1) >= span)
        begin
            hit = 1'b1;
            for (int i = 0; i < span && hit; i++)
            begin
                lag = span - 1 - i;
                h = (lag == 0) ? d : win_bytes[lag-1];
                if (!(h == ndl[i] || (ndl_caseless && h == to_lower(ndl[i]))))
                    hit = 1'b0;
            end
            if (hit)
            begin
                r.found = 1'b1;
                r.start_offset = hay_count - 32'(span - 1);
                pending_matches.push_back(r);
                hay_reported = 1'b1;
            end
        end
        if (last)
        begin
            if (!hay_reported)
            begin
                r.found = 1'b0;
                r.start_offset = '0;
                pending_matches.push_back(r);
            end
            clear_haystack();
        end
        else
        begin
            for (int i = WIN_DEPTH - 1; i > 0; i--)
                win_bytes[i] = win_bytes[i-1];
            win_bytes[0] = d;
            if (hay_count != '1)
                hay_count++;
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_NEEDLE_LOW:  for (int k = 0; k < 8; k++) ndl[k] = val[8*k +: 8];
            CFG_NEEDLE_HIGH: for (int k = 0; k < 8; k++) ndl[8+k] = val[8*k +: 8];
            CFG_NEEDLE_LEN:  ndl_len = val[NEEDLE_LEN_W-1:0];
            CFG_CASELESS:    ndl_caseless = val[0];
            default: ;
        endcase
    endtask

    task automatic load_needle(input logic [127:0] nb, input logic [63:0] len_word,
                               input logic cl);
        write_reg(CFG_NEEDLE_LOW, nb[63:0]);
        write_reg(CFG_NEEDLE_HIGH, nb[127:64]);
        write_reg(CFG_NEEDLE_LEN, len_word);
        write_reg(CFG_CASELESS, {63'd0, cl});
    endtask

    // Offer one byte after a random gap, or none when steady, and hold it until the transfer.
    task automatic send_byte(input logic [7:0] d, input logic last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        scan_byte(d, last);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Receiver: random stalls unless steady, plus a long hold-off when one is requested.
    initial
    begin : result_sink
        int gap;
        forever
        begin
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            gap = steady ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_matches.size() == 0)
                log_error($sformatf("unexpected result: found=%0b offset=%0d",
                                    m_tuser, m_tdata));
            else
            begin
                want = pending_matches.pop_front();
                if (want.found !== m_tuser || want.start_offset !== m_tdata)
                    log_error($sformatf(
                        "result mismatch: expected found=%0b offset=%0d, got found=%0b offset=%0d",
                        want.found, want.start_offset, m_tuser, m_tdata));
            end
        end
    end

    // Needle length still zero from reset: the haystack must end not-found.
    task automatic test_reset_defaults();
        send_text("hi");
        wait_idle();
    endtask

    task automatic test_exact_match();
        load_needle(pack_text("Ab"), 64'd2, 1'b0);
        send_text("xAb");
        wait_idle();
    endtask

    task automatic test_caseless_match();
        // match mid-haystack, then a silent final byte
        load_needle(pack_text("AB"), 64'd2, 1'b1);
        send_text("abQ");
        wait_idle();
        // one-byte needle matches on its own
        load_needle(pack_text("Z"), 64'd1, 1'b1);
        send_text("z");
        wait_idle();
        // only the needle side is lowered, so an upper haystack byte misses
        load_needle(pack_text("a"), 64'd1, 1'b1);
        send_text("A");
        wait_idle();
    endtask

    // Earlier haystacks must not contribute bytes to a match.
    task automatic test_short_haystack();
        load_needle(pack_text("abc"), 64'd3, 1'b0);
        send_text("ab");
        send_text("c");
        wait_idle();
    endtask

    // Sixteen-byte needle of 00/FF, its length written halfway through the
    // haystack with an oversized, garbage-topped value.
    task automatic test_full_needle();
        logic [127:0] nb;
        nb = {8{16'h00FF}};
        load_needle(nb, 64'd0, 1'b0);
        for (int i = 0; i < 8; i++)
            send_byte(nb[8*i +: 8], 1'b0);
        wait_idle();
        write_reg(CFG_NEEDLE_LEN, 64'hFFFF_FFFF_FFFF_FFF4);
        for (int i = 8; i < 16; i++)
            send_byte(nb[8*i +: 8], i == 15);
        wait_idle();
    endtask

    // Every byte ends a haystack, so each one yields a result while the
    // receiver holds off and the result buffer fills.
    task automatic test_backpressure();
        load_needle(pack_text("x"), 64'd1, 1'b0);
        rx_hold = 60;
        for (int i = 0; i < 40; i++)
            send_byte($urandom_range(0, 1) ? 8'h78 : 8'h79, 1'b1);
        wait_idle();
    endtask

    function automatic logic [7:0] pick_needle_byte();
        case ($urandom_range(0, 7))
            0:       return 8'(8'h41 + $urandom_range(0, 25));
            1:       return 8'(8'h61 + $urandom_range(0, 25));
            2:       return 8'h00;
            3:       return 8'hFF;
            4:       return 8'h41;
            5:       return 8'h61;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_random_haystacks(input int n_bytes);
        int          sent;
        int          phase;
        int          span;
        int          hlen;
        int          pos;
        int          pick;
        logic [127:0] nb;
        logic [63:0] len_word;
        logic [4:0]  len_val;
        logic [7:0]  hay [$];
        logic [7:0]  b;
        sent  = 0;
        phase = 0;
        while (sent < n_bytes)
        begin
            wait_idle();
            pick = $urandom_range(0, 99);
            if (pick < 5)
                len_val = 5'd0;
            else if (pick < 65)
                len_val = 5'($urandom_range(1, 6));
            else if (pick < 95)
                len_val = 5'($urandom_range(7, 16));
            else
                len_val = 5'($urandom_range(17, 31));
            for (int k = 0; k < 16; k++)
                nb[8*k +: 8] = pick_needle_byte();
            len_word = {$urandom, $urandom};
            if ($urandom_range(0, 1))
                len_word = '0;
            len_word[4:0] = len_val;
            load_needle(nb, len_word, 1'($urandom_range(0, 1)));
            steady = (phase % 5 == 3);
            span = needle_span();
            for (int h = 0; h < 6; h++)
            begin
                hay.delete();
                hlen = $urandom_range(1, 2 * span + 12);
                for (int i = 0; i < hlen; i++)
                begin
                    if (span > 0 && $urandom_range(0, 9) < 7)
                    begin
                        b = ndl[$urandom_range(0, span - 1)];
                        if ($urandom_range(0, 3) == 0)
                            b = to_lower(b);
                    end
                    else
                        b = 8'($urandom_range(0, 255));
                    hay.push_back(b);
                end
                // plant the needle, letters lowered now and then
                if (span > 0 && hlen >= span && $urandom_range(0, 1))
                begin
                    pos = $urandom_range(0, hlen - span);
                    for (int k = 0; k < span; k++)
                        hay[pos+k] = (ndl_caseless && $urandom_range(0, 1)) ?
                                     to_lower(ndl[k]) : ndl[k];
                end
                for (int i = 0; i < hlen; i++)
                    send_byte(hay[i], i == hlen - 1);
                sent += hlen;
            end
            phase++;
        end
        steady = 1'b0;
        wait_idle();
    endtask

    initial
    begin
        clear_haystack();
        for (int k = 0; k < NEEDLE_MAX_DEF; k++)
            ndl[k] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_exact_match();
        test_caseless_match();
        test_short_haystack();
        test_full_needle();
        test_backpressure();
        test_random_haystacks(RANDOM_BYTES);

        wait_idle();
        if (errors == 0 && pending_matches.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
